// ===== rtl/core/dste_pkg.sv =====
package dste_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MAC_W    = 48;
    localparam int TAG_W    = 64;
    localparam int RSSI_W   = 8;
    localparam int TIME_W   = 32;
    localparam int TIME_S_W = 23;
    localparam int SEEN_W   = 16;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;

    localparam logic [31:0] SAVE_INTERVAL_RST   = 32'd60000;
    localparam logic [31:0] NEW_ENTRY_FLUSH_RST = 32'd2000;

    // ms -> s: (t * ceil(2^38 / 1000)) >> 38, exact for all 32-bit t
    localparam int          DIV_MAGIC_W = 29;
    localparam logic [DIV_MAGIC_W-1:0] DIV1000_MAGIC = 29'd274877907;
    localparam int          DIV_SHIFT   = 38;
    localparam int          PROD_W      = TIME_W + DIV_MAGIC_W;

    // register byte addresses
    localparam logic [2:0] ADDR_SAVE_INTERVAL   = 3'd0;
    localparam logic [2:0] ADDR_NEW_ENTRY_FLUSH = 3'd4;

    localparam logic ACT_SIGHTING = 1'b0;
    localparam logic ACT_FLUSH    = 1'b1;

    typedef struct packed {
        logic [MAC_W-1:0]         mac;
        logic [TAG_W-1:0]         name;
        logic [TIME_S_W-1:0]      created;
        logic [SEEN_W-1:0]        seen;
        logic signed [RSSI_W-1:0] peak;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic scan_init;
        logic scan_run;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_flush;
        logic scan_done;
        logic out_busy;
    } status_t;

endpackage

// ===== rtl/core/dste_ram.sv =====
module dste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/dste_ctrl.sv =====
module dste_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dste_pkg::status_t status,
    output dste_pkg::cmd_t    cmd
);
    import dste_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = status.is_flush ? ST_COMMIT : ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL: begin
                cmd.mul       = 1'b1;
                cmd.scan_init = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = !status.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/dste_dp.sv =====
module dste_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dste_pkg::cmd_t                        cmd,
    output dste_pkg::status_t                     status,
    input  logic [31:0]                           flush_period_ms,
    input  logic [31:0]                           fresh_flush_ms,
    input  logic                                  s_action,
    input  logic [dste_pkg::MAC_W-1:0]            s_mac_address,
    input  logic [dste_pkg::TAG_W-1:0]            s_name_tag,
    input  logic signed [dste_pkg::RSSI_W-1:0]    s_rssi,
    input  logic [dste_pkg::TIME_W-1:0]           s_time_ms,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [dste_pkg::SLOT_W-1:0]           m_slot,
    output logic                                  m_evicted,
    output logic [dste_pkg::COUNT_W-1:0]          m_entry_count,
    output logic [dste_pkg::SEEN_W-1:0]           m_seen_count,
    output logic signed [dste_pkg::RSSI_W-1:0]    m_peak_rssi,
    output logic [dste_pkg::TIME_S_W-1:0]         m_first_seen_s,
    output logic                                  m_flush_due
);
    import dste_pkg::*;

    // latched item
    logic                     item_action_reg;
    logic [MAC_W-1:0]         item_mac_reg;
    logic [TAG_W-1:0]         item_tag_reg;
    logic signed [RSSI_W-1:0] item_rssi_reg;
    logic [TIME_W-1:0]        item_time_reg;
    logic [PROD_W-1:0]        prod_reg;

    // table bookkeeping
    logic [CNT_W-1:0]  used_count_reg;
    logic [CNT_W-1:0]  used_count_next;
    logic              dirty_reg;
    logic              dirty_next;
    logic              urgent_reg;
    logic              urgent_next;
    logic [TIME_W-1:0] last_flush_reg;
    logic [TIME_W-1:0] last_flush_next;

    // scan
    logic [CNT_W-1:0]    scan_idx_reg;
    logic                pend_vld_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    entry_t              hit_entry_reg;
    logic                min_first_reg;
    logic [TIME_S_W-1:0] min_created_reg;
    logic [IDX_W-1:0]    min_idx_reg;
    logic                issue;
    logic                match_now;
    entry_t              rd_entry;
    logic [ENTRY_W-1:0]  rd_data;

    // commit
    logic [TIME_S_W-1:0] now_s;
    logic                full;
    logic [IDX_W-1:0]    slot_idx;
    entry_t              new_entry;
    logic [TIME_W-1:0]   since;
    logic                due;
    logic                wr_en;
    logic [31:0]         slot_wide;
    logic [31:0]         count_wide;

    // result register
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic                     m_hit_reg;
    logic [SLOT_W-1:0]        m_slot_reg;
    logic                     m_evicted_reg;
    logic [COUNT_W-1:0]       m_entry_count_reg;
    logic [SEEN_W-1:0]        m_seen_count_reg;
    logic signed [RSSI_W-1:0] m_peak_rssi_reg;
    logic [TIME_S_W-1:0]      m_first_seen_s_reg;
    logic                     m_flush_due_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_action_reg <= s_action;
            item_mac_reg    <= s_mac_address;
            item_tag_reg    <= s_name_tag;
            item_rssi_reg   <= s_rssi;
            item_time_reg   <= s_time_ms;
        end
        if (cmd.mul) begin
            prod_reg <= item_time_reg * DIV1000_MAGIC;
        end
    end

    // ---------------- table scan: one read issued per cycle ----------------
    assign rd_entry  = entry_t'(rd_data);
    assign match_now = pend_vld_reg && !hit_reg && (rd_entry.mac == item_mac_reg);
    assign issue     = cmd.scan_run && !hit_reg && !match_now &&
                       (scan_idx_reg < used_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
        end else if (cmd.scan_init) begin
            pend_vld_reg <= 1'b0;
        end else if (cmd.scan_run) begin
            pend_vld_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            scan_idx_reg  <= '0;
            hit_reg       <= 1'b0;
            min_first_reg <= 1'b1;
        end else if (cmd.scan_run) begin
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                pend_idx_reg <= scan_idx_reg[IDX_W-1:0];
            end
            if (match_now) begin
                hit_reg       <= 1'b1;
                hit_idx_reg   <= pend_idx_reg;
                hit_entry_reg <= rd_entry;
            end
            if (pend_vld_reg && !hit_reg &&
                (min_first_reg || (rd_entry.created < min_created_reg))) begin
                min_first_reg   <= 1'b0;
                min_created_reg <= rd_entry.created;
                min_idx_reg     <= pend_idx_reg;
            end
        end
    end

    // ---------------- commit ----------------
    assign now_s = prod_reg[DIV_SHIFT +: TIME_S_W];
    assign full  = (used_count_reg == CNT_W'(TABLE_DEPTH));
    assign since = item_time_reg - last_flush_reg;
    assign due   = dirty_reg && ((since >= flush_period_ms) ||
                                 (urgent_reg && (since >= fresh_flush_ms)));
    assign wr_en = cmd.commit && (item_action_reg == ACT_SIGHTING);

    always_comb begin
        new_entry = hit_entry_reg;
        slot_idx  = hit_idx_reg;
        if (hit_reg) begin
            new_entry.seen = hit_entry_reg.seen + 1'b1;
            if (item_rssi_reg > hit_entry_reg.peak) begin
                new_entry.peak = item_rssi_reg;
            end
            if ((item_tag_reg != '0) && (hit_entry_reg.name == '0)) begin
                new_entry.name = item_tag_reg;
            end
        end else begin
            slot_idx          = full ? min_idx_reg : used_count_reg[IDX_W-1:0];
            new_entry.mac     = item_mac_reg;
            new_entry.name    = item_tag_reg;
            new_entry.created = now_s;
            new_entry.seen    = SEEN_W'(1);
            new_entry.peak    = item_rssi_reg;
        end
    end

    always_comb begin
        used_count_next = used_count_reg;
        dirty_next      = dirty_reg;
        urgent_next     = urgent_reg;
        last_flush_next = last_flush_reg;
        if (cmd.commit) begin
            if (item_action_reg == ACT_FLUSH) begin
                if (due) begin
                    dirty_next      = 1'b0;
                    urgent_next     = 1'b0;
                    last_flush_next = item_time_reg;
                end
            end else begin
                dirty_next = 1'b1;
                if (!hit_reg) begin
                    urgent_next = 1'b1;
                    if (!full) begin
                        used_count_next = used_count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_count_reg <= '0;
            dirty_reg      <= 1'b0;
            urgent_reg     <= 1'b0;
            last_flush_reg <= '0;
        end else begin
            used_count_reg <= used_count_next;
            dirty_reg      <= dirty_next;
            urgent_reg     <= urgent_next;
            last_flush_reg <= last_flush_next;
        end
    end

    dste_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot_idx),
        .wr_data (new_entry),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // ---------------- result register ----------------
    assign slot_wide    = 32'(slot_idx);
    assign count_wide   = 32'(used_count_next);
    assign m_valid_next = cmd.commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_entry_count_reg <= count_wide[COUNT_W-1:0];
            if (item_action_reg == ACT_FLUSH) begin
                m_hit_reg          <= 1'b0;
                m_slot_reg         <= '0;
                m_evicted_reg      <= 1'b0;
                m_seen_count_reg   <= '0;
                m_peak_rssi_reg    <= '0;
                m_first_seen_s_reg <= '0;
                m_flush_due_reg    <= due;
            end else begin
                m_hit_reg          <= hit_reg;
                m_slot_reg         <= slot_wide[SLOT_W-1:0];
                m_evicted_reg      <= !hit_reg && full;
                m_seen_count_reg   <= new_entry.seen;
                m_peak_rssi_reg    <= new_entry.peak;
                m_first_seen_s_reg <= new_entry.created;
                m_flush_due_reg    <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_slot         = m_slot_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_entry_count  = m_entry_count_reg;
    assign m_seen_count   = m_seen_count_reg;
    assign m_peak_rssi    = m_peak_rssi_reg;
    assign m_first_seen_s = m_first_seen_s_reg;
    assign m_flush_due    = m_flush_due_reg;

    assign status.is_flush  = (item_action_reg == ACT_FLUSH);
    assign status.scan_done = !pend_vld_reg && (hit_reg || (scan_idx_reg >= used_count_reg));
    assign status.out_busy  = m_valid_reg && !m_ready;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !status.out_busy)
        else $error("commit while result beat still stalled");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_evicted_reg) |-> (used_count_reg == CNT_W'(TABLE_DEPTH)))
        else $error("eviction reported on a table that is not full");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_evicted_reg))
        else $error("hit and eviction in one result");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("result beat raised without a commit");

endmodule

// ===== rtl/core/device_sighting_table_oldest_evict_top.sv =====
// Sequence: a sighting is compared against the table entries in use until its MAC matches
//   or all are read; a flush check skips the scan. Either then commits once the result
//   register is free to take it.
// Throughput: one item at a time; the table scan reads one entry per cycle through the
//   single read port of the entry RAM.
// Reset (aresetn low, synchronous): table empty, dirty/urgent marks and save time cleared,
//   registers back to 60000 ms and 2000 ms. Entry RAM contents are not cleared.
module device_sighting_table_oldest_evict_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // input beats
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [dste_pkg::MAC_W-1:0]            s_mac_address,
    input  logic [dste_pkg::TAG_W-1:0]            s_name_tag,
    input  logic signed [dste_pkg::RSSI_W-1:0]    s_rssi,
    input  logic [dste_pkg::TIME_W-1:0]           s_time_ms,
    // result beats
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [dste_pkg::SLOT_W-1:0]           m_slot,
    output logic                                  m_evicted,
    output logic [dste_pkg::COUNT_W-1:0]          m_entry_count,
    output logic [dste_pkg::SEEN_W-1:0]           m_seen_count,
    output logic signed [dste_pkg::RSSI_W-1:0]    m_peak_rssi,
    output logic [dste_pkg::TIME_S_W-1:0]         m_first_seen_s,
    output logic                                  m_flush_due
);
    import dste_pkg::*;

    logic [31:0] save_interval_reg;
    logic [31:0] new_entry_flush_reg;
    logic        cfg_wr;
    cmd_t        cmd;
    status_t     status;

    // Config registers. Word index is paddr[2]; the write lands on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            save_interval_reg   <= SAVE_INTERVAL_RST;
            new_entry_flush_reg <= NEW_ENTRY_FLUSH_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                new_entry_flush_reg <= pwdata;
            end else begin
                save_interval_reg <= pwdata;
            end
        end
    end

    // Misaligned reads return zero.
    always_comb begin
        case (paddr)
            ADDR_SAVE_INTERVAL:   prdata = save_interval_reg;
            ADDR_NEW_ENTRY_FLUSH: prdata = new_entry_flush_reg;
            default:              prdata = '0;
        endcase
    end

    // Sequencer: IDLE -> MUL (ms->s product, scan setup) -> SCAN -> COMMIT; a flush skips SCAN.
    dste_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Entry RAM, match/oldest search, bookkeeping and the result register.
    dste_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .flush_period_ms    (save_interval_reg),
        .fresh_flush_ms     (new_entry_flush_reg),
        .s_action           (s_action),
        .s_mac_address      (s_mac_address),
        .s_name_tag         (s_name_tag),
        .s_rssi             (s_rssi),
        .s_time_ms          (s_time_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit              (m_hit),
        .m_slot             (m_slot),
        .m_evicted          (m_evicted),
        .m_entry_count      (m_entry_count),
        .m_seen_count       (m_seen_count),
        .m_peak_rssi        (m_peak_rssi),
        .m_first_seen_s     (m_first_seen_s),
        .m_flush_due        (m_flush_due)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dste_pkg::*;

    localparam int MAX_GAP      = 13;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
    localparam int REPEAT_HITS  = 40;
    localparam int MAC_POOL     = 320;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 240;

    typedef struct {
        logic                     action;
        logic [MAC_W-1:0]         mac;
        logic [TAG_W-1:0]         tag;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        tms;
    } sighting_t;

    typedef struct {
        logic                     hit;
        logic [SLOT_W-1:0]        slot;
        logic                     evicted;
        logic [COUNT_W-1:0]       count;
        logic [SEEN_W-1:0]        seen;
        logic signed [RSSI_W-1:0] peak;
        logic [TIME_S_W-1:0]      first;
        logic                     due;
    } table_reply_t;

    // clock, reset, config port
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // input beats
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_action      = 1'b0;
    logic [MAC_W-1:0]         s_mac_address = '0;
    logic [TAG_W-1:0]         s_name_tag    = '0;
    logic signed [RSSI_W-1:0] s_rssi        = '0;
    logic [TIME_W-1:0]        s_time_ms     = '0;

    // result beats
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_hit;
    logic [SLOT_W-1:0]        m_slot;
    logic                     m_evicted;
    logic [COUNT_W-1:0]       m_entry_count;
    logic [SEEN_W-1:0]        m_seen_count;
    logic signed [RSSI_W-1:0] m_peak_rssi;
    logic [TIME_S_W-1:0]      m_first_seen_s;
    logic                     m_flush_due;

    always #1 aclk = ~aclk;

    device_sighting_table_oldest_evict_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_mac_address (s_mac_address),
        .s_name_tag    (s_name_tag),
        .s_rssi        (s_rssi),
        .s_time_ms     (s_time_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_slot        (m_slot),
        .m_evicted     (m_evicted),
        .m_entry_count (m_entry_count),
        .m_seen_count  (m_seen_count),
        .m_peak_rssi   (m_peak_rssi),
        .m_first_seen_s(m_first_seen_s),
        .m_flush_due   (m_flush_due)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the device table and flush bookkeeping.
    // Only entries below dev_used are ever read.
    // ------------------------------------------------------------------
    logic [MAC_W-1:0]         dev_mac   [TABLE_DEPTH];
    logic [TAG_W-1:0]         dev_name  [TABLE_DEPTH];
    logic [TIME_S_W-1:0]      dev_first [TABLE_DEPTH];
    logic [TIME_S_W-1:0]      dev_last  [TABLE_DEPTH];
    logic [SEEN_W-1:0]        dev_seen  [TABLE_DEPTH];
    logic signed [RSSI_W-1:0] dev_peak  [TABLE_DEPTH];
    int unsigned              dev_used        = 0;
    logic                     dirty           = 1'b0;
    logic                     urgent          = 1'b0;
    logic [TIME_W-1:0]        saved_at_ms     = '0;
    logic [TIME_W-1:0]        save_interval   = SAVE_INTERVAL_RST;
    logic [TIME_W-1:0]        new_entry_flush = NEW_ENTRY_FLUSH_RST;

    table_reply_t replies_due [$];
    int unsigned  mismatches   = 0;
    bit           back_to_back = 1'b0; // no idling on either side while set
    bit           valid_held   = 1'b0; // s_valid scheduled high
    int unsigned  rx_hold      = 0;

    // Applies one beat to the shadow table and returns the reply it must give.
    function automatic table_reply_t update_table(input sighting_t it);
        table_reply_t        r;
        logic [TIME_W-1:0]   since;
        logic [TIME_S_W-1:0] now_s;
        int                  idx;
        int                  i;
        r = '{default: '0};
        now_s = TIME_S_W'(it.tms / 1000);
        if (it.action == ACT_FLUSH) begin
            since = it.tms - saved_at_ms;   // wraps mod 2^32
            r.due = dirty && (since >= save_interval ||
                              (urgent && since >= new_entry_flush));
            if (r.due) begin
                saved_at_ms = it.tms;
                dirty       = 1'b0;
                urgent      = 1'b0;
            end
            r.count = COUNT_W'(dev_used);
            return r;
        end
        idx = -1;
        for (i = 0; i < dev_used; i++) begin
            if (dev_mac[i] == it.mac) begin
                idx = i;
                break;
            end
        end
        if (idx >= 0) begin
            r.hit         = 1'b1;
            dev_last[idx] = now_s;
            dev_seen[idx] = dev_seen[idx] + 1'b1;
            if (it.rssi > dev_peak[idx])
                dev_peak[idx] = it.rssi;
            if (it.tag != '0 && dev_name[idx] == '0)
                dev_name[idx] = it.tag;
            dirty = 1'b1;
        end else begin
            if (dev_used < TABLE_DEPTH) begin
                idx = dev_used;
                dev_used++;
            end else begin
                // full: oldest first-seen goes, lowest index wins a tie
                r.evicted = 1'b1;
                idx = 0;
                for (i = 1; i < TABLE_DEPTH; i++)
                    if (dev_first[i] < dev_first[idx])
                        idx = i;
            end
            dev_mac[idx]   = it.mac;
            dev_name[idx]  = it.tag;
            dev_first[idx] = now_s;
            dev_last[idx]  = now_s;
            dev_seen[idx]  = 1;
            dev_peak[idx]  = it.rssi;
            dirty  = 1'b1;
            urgent = 1'b1;
        end
        r.slot  = SLOT_W'(idx);
        r.count = COUNT_W'(dev_used);
        r.seen  = dev_seen[idx];
        r.peak  = dev_peak[idx];
        r.first = dev_first[idx];
        return r;
    endfunction

    function automatic sighting_t sighting(input logic action, input logic [MAC_W-1:0] mac,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [RSSI_W-1:0] rssi,
                                           input logic [TIME_W-1:0] tms);
        sighting_t it;
        it.action = action;
        it.mac    = mac;
        it.tag    = tag;
        it.rssi   = rssi;
        it.tms    = tms;
        return it;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TAG_W-1:0] random_tag();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            report_mismatch(what, want, got);
    endtask

    // Drives one beat after a random gap and waits for it to be taken.
    task automatic send_sighting(input sighting_t it);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            if (valid_held)
                s_valid <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= it.action;
        s_mac_address <= it.mac;
        s_name_tag    <= it.tag;
        s_rssi        <= it.rssi;
        s_time_ms     <= it.tms;
        valid_held = 1'b1;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(update_table(it));
    endtask

    // Sender holds off until every pending reply has come back.
    task automatic wait_drain();
        if (valid_held)
            s_valid <= 1'b0;
        valid_held = 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // Writes both flush timers and reads each one back. Table must be idle.
    task automatic program_flush_timing(input logic [31:0] interval,
                                        input logic [31:0] urgent_ms);
        logic [2:0]  addr  [2];
        logic [31:0] value [2];
        logic [31:0] rd;
        int          k;
        addr  = '{ADDR_SAVE_INTERVAL, ADDR_NEW_ENTRY_FLUSH};
        value = '{interval, urgent_ms};
        psel <= 1'b1;
        for (k = 0; k < 2; k++) begin
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr[k];
            pwdata  <= value[k];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            // back-to-back read of the same register
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            @(negedge aclk);
            rd = prdata;
            do @(posedge aclk); while (!pready);
            check_field("register readback", value[k], rd);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        save_interval   = interval;
        new_entry_flush = urgent_ms;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls on m_ready, every beat checked in order.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        table_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("result beat with nothing pending", '0, '0);
            end else begin
                want = replies_due.pop_front();
                check_field("hit", want.hit, m_hit);
                check_field("slot", want.slot, m_slot);
                check_field("evicted", want.evicted, m_evicted);
                check_field("entry_count", want.count, m_entry_count);
                check_field("seen_count", want.seen, m_seen_count);
                check_field("peak_rssi", want.peak, m_peak_rssi);
                check_field("first_seen_s", want.first, m_first_seen_s);
                check_field("flush_due", want.due, m_flush_due);
            end
            rx_hold = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
            m_ready <= (rx_hold == 0);
        end else if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= (rx_hold == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Flush check on an empty, clean table: never due, count zero.
    task automatic test_empty_table();
        send_sighting(sighting(ACT_FLUSH, '1, '1, '1, '1));
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, '0));
    endtask

    // One entry hit over and over: count climbs, name filled once, peak tracked.
    // Run flat out: the table holds one entry, so each beat is short.
    task automatic test_repeat_hits();
        logic [MAC_W-1:0] rep_mac;
        int               n;
        rep_mac      = random_mac();
        back_to_back = 1'b1;
        send_sighting(sighting(ACT_SIGHTING, rep_mac, '0,
                               RSSI_W'($urandom_range(0, 255)), 0));
        for (n = 0; n < REPEAT_HITS; n++)
            send_sighting(sighting(ACT_SIGHTING, rep_mac, random_tag(),
                                   RSSI_W'($urandom_range(0, 255)),
                                   $urandom_range(0, 999)));
        wait_drain();
        back_to_back = 1'b0;
    endtask

    // Dirty / urgent rules, time wrap, and both timers at their extremes.
    // Entry 0 is the repeat entry; table is dirty and urgent, last save at 0.
    task automatic test_flush_rules();
        logic [MAC_W-1:0] mac_a;
        mac_a = dev_mac[0];
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 1000));    // too soon
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 2500));    // new-entry timer
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 2600));    // clean
        send_sighting(sighting(ACT_SIGHTING, mac_a, '0, -8'sd5, 3000)); // dirty only
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 5000));    // not urgent
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 62500));   // save interval
        send_sighting(sighting(ACT_SIGHTING, random_mac(), random_tag(), 8'sd3, 63000));
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 1000));    // uptime wrapped
        wait_drain();

        // interval zero: any change is due at once
        program_flush_timing(32'd0, 32'hFFFF_FFFF);
        send_sighting(sighting(ACT_SIGHTING, mac_a, '0, 8'sd0, 2000));
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 2000));
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 2000));
        wait_drain();

        // new-entry timer zero, interval at maximum
        program_flush_timing(32'hFFFF_FFFF, 32'd0);
        send_sighting(sighting(ACT_SIGHTING, mac_a, '0, 8'sd1, 3000));
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 4000));
        send_sighting(sighting(ACT_SIGHTING, random_mac(), '0, -8'sd70, 4000));
        send_sighting(sighting(ACT_FLUSH, '0, '0, '0, 4000));
    endtask

    // Field extremes, name fill on hit, peak kept and raised.
    task automatic test_field_extremes();
        send_sighting(sighting(ACT_SIGHTING, '0, '0, -8'sd128, 32'd0));
        send_sighting(sighting(ACT_SIGHTING, '0, '1, 8'sd127, 32'hFFFF_FFFF));
        send_sighting(sighting(ACT_SIGHTING, '1, '1, 8'sd127, 32'hFFFF_FFFF));
        send_sighting(sighting(ACT_SIGHTING, '1, 64'h5A5A_A5A5_0F0F_F0F0, -8'sd128, 32'd999));
        send_sighting(sighting(ACT_SIGHTING, 48'h8000_0000_0001, '0, 8'sd0, 32'd7000));
        send_sighting(sighting(ACT_SIGHTING, 48'h8000_0000_0001, random_tag(), 8'sd1, 32'd8000));
    endtask

    // Fill the table at a fixed time so many first-seen values tie,
    // then push a few more new devices to force replacement.
    task automatic test_fill_table();
        logic [TIME_W-1:0] fill_ms;
        int                n;
        fill_ms = 32'd10_000_000 + $urandom_range(0, 999);
        while (dev_used < TABLE_DEPTH)
            send_sighting(sighting(ACT_SIGHTING, random_mac(), random_tag(),
                                   RSSI_W'($urandom_range(0, 255)), fill_ms));
        for (n = 0; n < 4; n++)
            send_sighting(sighting(ACT_SIGHTING, random_mac(), '0,
                                   RSSI_W'($urandom_range(0, 255)), fill_ms));
    endtask

    // Mixed traffic over a recurring device pool, one timer setting per phase.
    task automatic test_random_traffic();
        logic [31:0]       intervals [PHASES];
        logic [31:0]       urgents   [PHASES];
        logic [MAC_W-1:0]  pool      [MAC_POOL];
        logic [MAC_W-1:0]  mac;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] now_ms;
        logic              action;
        int unsigned       pick;
        int                n;
        int                phase;
        intervals = '{SAVE_INTERVAL_RST, 32'd0, 32'hFFFF_FFFF,
                      $urandom_range(0, 20000), 32'hFFFF_FFFF, $urandom};
        urgents   = '{NEW_ENTRY_FLUSH_RST, 32'd0, 32'hFFFF_FFFF,
                      $urandom_range(0, 5000), 32'd0, $urandom};
        for (n = 0; n < MAC_POOL; n++)
            pool[n] = random_mac();
        now_ms = 32'd10_000_000;

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drain();
            back_to_back = 1'b0;
            program_flush_timing(intervals[phase], urgents[phase]);
            for (n = 0; n < PHASE_BEATS; n++) begin
                if (n % 80 == 0)
                    back_to_back = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 59) == 0)
                    wait_drain();
                if ($urandom_range(0, 49) == 0)
                    now_ms = $urandom;
                else
                    now_ms += $urandom_range(0, 1500);
                pick   = $urandom_range(0, 99);
                action = (pick < 14) ? ACT_FLUSH : ACT_SIGHTING;
                if (pick >= 14 && pick < 82)
                    mac = pool[$urandom_range(0, MAC_POOL - 1)];
                else
                    mac = random_mac();
                tag = ($urandom_range(0, 2) == 0) ? '0 : random_tag();
                send_sighting(sighting(action, mac, tag,
                                       RSSI_W'($urandom_range(0, 255)), now_ms));
            end
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_repeat_hits();
        test_flush_rules();
        test_field_extremes();
        test_fill_table();
        test_random_traffic();
        // drained, then watch for stray beats for a full scan time
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dste_pkg.sv
rtl/core/dste_ram.sv
rtl/core/dste_ctrl.sv
rtl/core/dste_dp.sv
rtl/core/device_sighting_table_oldest_evict_top.sv
tb/tb_top.sv
